// ===== rtl/sofr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofr_pkg
// Shared types and constants of the object fragment reassembler.
// ----------------------------------------------------------------------------
package sofr_pkg;

  // Configuration register indexes.
  localparam logic CFG_MAX_WIDTH  = 1'b0;
  localparam logic CFG_MAX_HEIGHT = 1'b1;

  // Data length in the header counts the four dimension bytes.
  localparam logic [23:0] LEN_BIAS = 24'd4;

  // Result queue depth.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  typedef enum logic [3:0] {
    ST_PARTIAL       = 4'd0,
    ST_COMPLETE      = 4'd1,
    ST_TRUNCATED     = 4'd2,
    ST_RESERVED      = 4'd3,
    ST_SHORT_LEN     = 4'd4,
    ST_ZERO_DIM      = 4'd5,
    ST_TOO_BIG       = 4'd6,
    ST_NOT_OPEN      = 4'd7,
    ST_VERSION       = 4'd8,
    ST_OVERFLOW      = 4'd9,
    ST_LAST_SHORT    = 4'd10,
    ST_FULL_NOT_LAST = 4'd11,
    ST_BAD_ID        = 4'd12
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_SKIP    = 3'b100
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [15:0] max_width;
    logic [15:0] max_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  version;
    logic [15:0] width;
    logic [15:0] height;
    logic [23:0] filled;
    logic [23:0] remaining;
    logic        open;
  } slot_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] obj_id;
    logic [23:0] buffer_offset;
    logic [7:0]  payload;
    status_e     status;
    logic [15:0] object_width;
    logic [15:0] object_height;
    logic [23:0] data_length;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic pending;
  } parser_stat_t;

  typedef struct packed {
    logic [FIFO_PTR_W:0] count;
  } fifo_stat_t;

endpackage

// ===== rtl/sofr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofr_if
// Segment byte channel and result channel.
// ----------------------------------------------------------------------------
interface sofr_seg_if;
  logic       valid;
  logic       ready;
  logic [7:0] seg_byte;
  logic       seg_last;

  modport source (output valid, output seg_byte, output seg_last, input ready);
  modport sink   (input valid, input seg_byte, input seg_last, output ready);
endinterface

interface sofr_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] obj_id;
  logic [23:0] buffer_offset;
  logic [7:0]  payload;
  logic [3:0]  status;
  logic [15:0] object_width;
  logic [15:0] object_height;
  logic [23:0] data_length;

  modport source (output valid, output result_kind, output obj_id,
                  output buffer_offset, output payload, output status,
                  output object_width, output object_height,
                  output data_length, input ready);
  modport sink   (input valid, input result_kind, input obj_id,
                  input buffer_offset, input payload, input status,
                  input object_width, input object_height,
                  input data_length, output ready);
endinterface

// ===== rtl/sofr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofr_parser
// Front end: parses segment bytes, keeps the object table and produces
// up to two results per accepted byte.
// ----------------------------------------------------------------------------
module sofr_parser import sofr_pkg::*; #(
  parameter int OBJECT_SLOTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  input  logic         room_i,
  output logic [1:0]   push_cnt_o,
  output result_t      res0_o,
  output result_t      res1_o,
  output parser_stat_t stat_o
);

  localparam int IDX_W = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
  localparam logic [16:0] SLOTS_L = 17'(OBJECT_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(OBJECT_SLOTS - 1);

  function automatic logic in_range(input logic [15:0] id);
    return {1'b0, id} < SLOTS_L;
  endfunction

  // Object table memory and its registered read port.
  slot_t mem [OBJECT_SLOTS];
  slot_t rd_q;

  // Segment state.
  phase_e      phase_q, phase_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  ver_q, ver_d;
  logic [1:0]  flags_q, flags_d;
  logic [23:0] dlen_q, dlen_d;
  logic [15:0] hw_q, hw_d;
  logic [15:0] hh_q, hh_d;
  status_e     err_q, err_d;

  // Cached copy of the current object's slot.
  slot_t       slot_q, slot_d, view;
  logic        ld_q, ld_d;
  logic        pend_q, pend_d;
  logic        clr_q;
  logic [IDX_W-1:0] clr_cnt_q;
  logic        wr_en;
  logic        acc;
  logic [15:0] hh_full;
  logic        known;
  status_e     code;
  result_t     stat_res;

  assign in_ready_o = !clr_q && !pend_q && room_i;
  assign acc        = in_valid_i && in_ready_o;
  assign stat_o     = '{clearing: clr_q, pending: pend_q};
  assign view       = ld_q ? rd_q : slot_q;
  assign hh_full    = {hh_q[15:8], byte_i};

  // Parsing and table update for one byte.
  always_comb begin
    phase_d = phase_q; hcnt_d = hcnt_q; id_d = id_q; ver_d = ver_q;
    flags_d = flags_q; dlen_d = dlen_q; hw_d = hw_q; hh_d = hh_q;
    err_d = err_q; slot_d = view; wr_en = 1'b0;
    ld_d = 1'b0; pend_d = 1'b0;
    push_cnt_o = 2'd0; res0_o = '0; res1_o = '0;
    known = 1'b0; code = ST_PARTIAL; stat_res = '0;

    if (pend_q) begin
      // Segment ended on the second id byte; the slot read has now landed.
      stat_res.kind          = KIND_STATUS;
      stat_res.obj_id        = id_q;
      stat_res.status        = ST_TRUNCATED;
      stat_res.object_width  = view.width;
      stat_res.object_height = view.height;
      stat_res.data_length   = view.filled;
      res0_o = stat_res;
      push_cnt_o = 2'd1;
      phase_d = PH_HEADER; hcnt_d = '0; id_d = '0; ver_d = '0; flags_d = '0;
      dlen_d = '0; hw_d = '0; hh_d = '0; err_d = ST_PARTIAL;
    end else if (acc) begin
      unique case (phase_q)
        PH_HEADER: begin
          unique case (hcnt_q)
            4'd0: id_d = {byte_i, 8'd0};
            4'd1: begin
              id_d = {id_q[15:8], byte_i};
              ld_d = 1'b1;
            end
            4'd2: ver_d = byte_i;
            4'd3: begin
              if (byte_i[5:0] != 6'd0) begin
                err_d = ST_RESERVED; phase_d = PH_SKIP;
              end else begin
                flags_d = byte_i[7:6];
                if (!in_range(id_q)) begin
                  err_d = ST_BAD_ID; phase_d = PH_SKIP;
                end else if (!byte_i[7]) begin
                  if (!view.open || view.remaining == 24'd0) begin
                    err_d = ST_NOT_OPEN; phase_d = PH_SKIP;
                  end else if (view.version != ver_q) begin
                    err_d = ST_VERSION; phase_d = PH_SKIP;
                  end else begin
                    phase_d = PH_PAYLOAD;
                  end
                end
              end
            end
            4'd4, 4'd5, 4'd6: dlen_d = {dlen_q[15:0], byte_i};
            4'd7, 4'd8: hw_d = {hw_q[7:0], byte_i};
            4'd9: hh_d = {byte_i, 8'd0};
            default: begin
              hh_d = hh_full;
              if (dlen_q < LEN_BIAS) begin
                err_d = ST_SHORT_LEN; phase_d = PH_SKIP;
              end else if (hw_q == 16'd0 || hh_full == 16'd0) begin
                err_d = ST_ZERO_DIM; phase_d = PH_SKIP;
              end else if (cfg_i.max_width != 16'd0 && cfg_i.max_height != 16'd0 &&
                           (hw_q > cfg_i.max_width ||
                            hh_full > cfg_i.max_height)) begin
                err_d = ST_TOO_BIG; phase_d = PH_SKIP;
              end else if (!in_range(id_q)) begin
                err_d = ST_BAD_ID; phase_d = PH_SKIP;
              end else begin
                slot_d.version   = ver_q;
                slot_d.width     = hw_q;
                slot_d.height    = hh_full;
                slot_d.filled    = 24'd0;
                slot_d.remaining = dlen_q - LEN_BIAS;
                slot_d.open      = (dlen_q - LEN_BIAS) != 24'd0;
                wr_en   = 1'b1;
                phase_d = PH_PAYLOAD;
              end
            end
          endcase
          if (hcnt_q != 4'd15) hcnt_d = hcnt_q + 4'd1;
        end
        PH_PAYLOAD: begin
          if (!in_range(id_q)) begin
            err_d = ST_BAD_ID; phase_d = PH_SKIP;
          end else if (view.remaining == 24'd0) begin
            err_d = ST_OVERFLOW; phase_d = PH_SKIP;
          end else begin
            res0_o.kind          = KIND_PAYLOAD;
            res0_o.obj_id        = id_q;
            res0_o.buffer_offset = view.filled;
            res0_o.payload       = byte_i;
            res0_o.status        = ST_PARTIAL;
            push_cnt_o = 2'd1;
            slot_d.filled    = view.filled + 24'd1;
            slot_d.remaining = view.remaining - 24'd1;
            wr_en = 1'b1;
          end
        end
        PH_SKIP: ;
        default: ;
      endcase

      // Segment end: status from the state this byte leaves.
      if (last_i) begin
        if (hcnt_q == 4'd1 && in_range(id_d)) begin
          pend_d = 1'b1;
        end else begin
          known = (hcnt_d >= 4'd2) && in_range(id_d);
          if (err_d != ST_PARTIAL) begin
            code = err_d;
          end else if (phase_d != PH_PAYLOAD || !known) begin
            code = ST_TRUNCATED;
          end else if (flags_d[0]) begin
            code = (slot_d.remaining != 24'd0) ? ST_LAST_SHORT : ST_COMPLETE;
          end else begin
            code = (slot_d.remaining == 24'd0) ? ST_FULL_NOT_LAST : ST_PARTIAL;
          end
          stat_res.kind      = KIND_STATUS;
          stat_res.obj_id    = id_d;
          stat_res.status    = code;
          if (known) begin
            stat_res.object_width  = slot_d.width;
            stat_res.object_height = slot_d.height;
            stat_res.data_length   = slot_d.filled;
          end
          if (push_cnt_o == 2'd1) begin
            res1_o = stat_res;
            push_cnt_o = 2'd2;
          end else begin
            res0_o = stat_res;
            push_cnt_o = 2'd1;
          end
          phase_d = PH_HEADER; hcnt_d = '0; id_d = '0; ver_d = '0;
          flags_d = '0; dlen_d = '0; hw_d = '0; hh_d = '0; err_d = ST_PARTIAL;
        end
      end
    end
  end

  // Segment control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hcnt_q <= '0; id_q <= '0; ver_q <= '0;
      flags_q <= '0; dlen_q <= '0; hw_q <= '0; hh_q <= '0;
      err_q <= ST_PARTIAL; ld_q <= 1'b0; pend_q <= 1'b0;
      clr_q <= 1'b1; clr_cnt_q <= '0;
    end else begin
      phase_q <= phase_d; hcnt_q <= hcnt_d; id_q <= id_d; ver_q <= ver_d;
      flags_q <= flags_d; dlen_q <= dlen_d; hw_q <= hw_d; hh_q <= hh_d;
      err_q <= err_d; ld_q <= ld_d; pend_q <= pend_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_IDX) clr_q <= 1'b0;
      end
    end
  end

  // Slot cache.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // Table memory: clearing pass after reset, then write-back of the cache.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      mem[id_q[IDX_W-1:0]] <= slot_d;
    end
    rd_q <= mem[id_d[IDX_W-1:0]];
  end

endmodule

// ===== rtl/sofr_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofr_result_fifo
// Short result queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
module sofr_result_fifo import sofr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  result_t    d0_i,
  input  result_t    d1_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output result_t    q_o,
  output fifo_stat_t stat_o
);

  result_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wp_q, rp_q;
  logic [FIFO_PTR_W:0]    cnt_q, cnt_d;
  logic                   pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign q_o     = entries[rp_q];
  assign room_o  = cnt_q <= (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2);
  assign stat_o  = '{count: cnt_q};
  assign cnt_d   = cnt_q + {1'b0, push_cnt_i} - {{FIFO_PTR_W{1'b0}}, pop};

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + push_cnt_i[FIFO_PTR_W-1:0];
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) entries[wp_q] <= d0_i;
    if (push_cnt_i == 2'd2) entries[wp_q + 1'b1] <= d1_i;
  end

endmodule

// ===== rtl/subtitle_object_fragment_reassembler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_object_fragment_reassembler_unit
// Reassembles object definition segments into payload bytes and status.
// ----------------------------------------------------------------------------
// The block takes one segment byte per cycle, while it is not clearing, has no
// deferred status pending and its result queue has room for two results, and
// gives each payload byte with its buffer offset, plus one status result on the
// segment's last byte; the rate is set by the read-modify-write of the cached
// object slot, and the two-result cycles are absorbed by a four-entry result
// queue. A segment that ends on its second id byte gets its status only once
// the registered object table read has landed. After reset a clearing pass zeroes
// the table; no byte is taken during it, while configuration writes are.
module subtitle_object_fragment_reassembler_unit import sofr_pkg::*; #(
  parameter int OBJECT_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  sofr_seg_if.sink    seg_in,
  sofr_res_if.source  res_out
);

  cfg_t         cfg_q;
  logic         room;
  logic [1:0]   push_cnt;
  result_t      res0, res1, head;
  parser_stat_t pstat;
  fifo_stat_t   fstat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_WIDTH:  cfg_q.max_width  <= cfg_data_i;
        CFG_MAX_HEIGHT: cfg_q.max_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end.
  sofr_parser #(.OBJECT_SLOTS(OBJECT_SLOTS)) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (seg_in.valid),
    .in_ready_o (seg_in.ready),
    .byte_i     (seg_in.seg_byte),
    .last_i     (seg_in.seg_last),
    .room_i     (room),
    .push_cnt_o (push_cnt),
    .res0_o     (res0),
    .res1_o     (res1),
    .stat_o     (pstat)
  );

  // Result queue and output channel.
  sofr_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .d0_i       (res0),
    .d1_i       (res1),
    .room_o     (room),
    .valid_o    (res_out.valid),
    .ready_i    (res_out.ready),
    .q_o        (head),
    .stat_o     (fstat)
  );

  assign res_out.result_kind   = head.kind;
  assign res_out.obj_id        = head.obj_id;
  assign res_out.buffer_offset = head.buffer_offset;
  assign res_out.payload       = head.payload;
  assign res_out.status        = head.status;
  assign res_out.object_width  = head.object_width;
  assign res_out.object_height = head.object_height;
  assign res_out.data_length   = head.data_length;

`ifndef NO_ASSERTIONS
  // No byte is taken while the table is being cleared.
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pstat.clearing |-> !seg_in.ready)
    else $error("byte taken during table clear");

  // The result queue never holds more than its depth.
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A segment end leaves a status queued or a deferred status pending.
  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_in.valid && seg_in.ready && seg_in.seg_last |=> res_out.valid || pstat.pending)
    else $error("segment end without status");
`endif

endmodule

// ===== dv/sofr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofr_checker
// Watches the segment and result channels of the fragment reassembler,
// predicts every result from the accepted segment bytes and compares them.
// ----------------------------------------------------------------------------
module sofr_checker import sofr_pkg::*; #(
  parameter int OBJECT_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  sofr_seg_if         seg,
  sofr_res_if         res,
  output int          fail_count,
  output int          pending_count
);

  localparam int PH_HDR = 0;
  localparam int PH_PAY = 1;
  localparam int PH_SKP = 2;

  // Configuration copy.
  logic [15:0] lim_width, lim_height;

  // Segment-level parser state.
  int          phase;
  int          hdr_count;
  logic [15:0] seg_id;
  logic [7:0]  seg_version;
  logic [1:0]  seg_flags;
  logic [23:0] seg_length;
  logic [15:0] seg_width, seg_height;
  status_e     seg_error;

  // Object table.
  logic [7:0]  tbl_version   [OBJECT_SLOTS];
  logic [15:0] tbl_width     [OBJECT_SLOTS];
  logic [15:0] tbl_height    [OBJECT_SLOTS];
  logic [23:0] tbl_filled    [OBJECT_SLOTS];
  logic [23:0] tbl_remaining [OBJECT_SLOTS];
  logic        tbl_open      [OBJECT_SLOTS];

  result_t expected_results[$];

  assign pending_count = expected_results.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_segment();
    phase = PH_HDR;
    hdr_count = 0;
    seg_id = '0;
    seg_version = '0;
    seg_flags = '0;
    seg_length = '0;
    seg_width = '0;
    seg_height = '0;
    seg_error = ST_PARTIAL;
  endfunction

  function automatic void latch_error(input status_e code);
    seg_error = code;
    phase = PH_SKP;
  endfunction

  // Header parsing of one byte; the id is the value before this byte.
  function automatic void take_header(input logic [7:0] b);
    logic [15:0] id;
    logic [15:0] hh;
    id = seg_id;
    case (hdr_count)
      0: seg_id = {b, 8'h00};
      1: seg_id = seg_id | {8'h00, b};
      2: seg_version = b;
      3: begin
        if ((b & 8'h3f) != 0) latch_error(ST_RESERVED);
        else begin
          seg_flags = b[7:6];
          if (id >= OBJECT_SLOTS) latch_error(ST_BAD_ID);
          else if (!b[7]) begin
            if (!tbl_open[id] || tbl_remaining[id] == 0) latch_error(ST_NOT_OPEN);
            else if (tbl_version[id] != seg_version) latch_error(ST_VERSION);
            else phase = PH_PAY;
          end
        end
      end
      4, 5, 6: seg_length = {seg_length[15:0], b};
      7, 8: seg_width = {seg_width[7:0], b};
      9: seg_height = {b, 8'h00};
      default: begin
        hh = seg_height | {8'h00, b};
        seg_height = hh;
        if (seg_length < LEN_BIAS) latch_error(ST_SHORT_LEN);
        else if (seg_width == 0 || hh == 0) latch_error(ST_ZERO_DIM);
        else if (lim_width != 0 && lim_height != 0 &&
                 (seg_width > lim_width || hh > lim_height))
          latch_error(ST_TOO_BIG);
        else if (id >= OBJECT_SLOTS) latch_error(ST_BAD_ID);
        else begin
          tbl_version[id]   = seg_version;
          tbl_width[id]     = seg_width;
          tbl_height[id]    = hh;
          tbl_filled[id]    = '0;
          tbl_remaining[id] = seg_length - LEN_BIAS;
          tbl_open[id]      = (seg_length - LEN_BIAS) != 0;
          phase = PH_PAY;
        end
      end
    endcase
    if (hdr_count < 15) hdr_count++;
  endfunction

  // Predict the results of one accepted segment byte.
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    result_t r;
    status_e code;
    logic    known;
    if (phase == PH_HDR) take_header(b);
    else if (phase == PH_PAY) begin
      if (seg_id >= OBJECT_SLOTS) latch_error(ST_BAD_ID);
      else if (tbl_remaining[seg_id] == 0) latch_error(ST_OVERFLOW);
      else begin
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.obj_id = seg_id;
        r.buffer_offset = tbl_filled[seg_id];
        r.payload = b;
        r.status = ST_PARTIAL;
        expected_results.push_back(r);
        tbl_filled[seg_id]++;
        tbl_remaining[seg_id]--;
      end
    end
    if (last) begin
      known = hdr_count >= 2 && seg_id < OBJECT_SLOTS;
      if (seg_error != ST_PARTIAL) code = seg_error;
      else if (phase != PH_PAY || !known) code = ST_TRUNCATED;
      else if (seg_flags[0]) code = tbl_remaining[seg_id] != 0 ? ST_LAST_SHORT : ST_COMPLETE;
      else code = tbl_remaining[seg_id] == 0 ? ST_FULL_NOT_LAST : ST_PARTIAL;
      r = '0;
      r.kind = KIND_STATUS;
      r.obj_id = seg_id;
      r.status = code;
      if (known) begin
        r.object_width = tbl_width[seg_id];
        r.object_height = tbl_height[seg_id];
        r.data_length = tbl_filled[seg_id];
      end
      expected_results.push_back(r);
      clear_segment();
    end
  endfunction

  // Track configuration and inputs, compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t w;
    if (!rst_ni) begin
      lim_width = '0;
      lim_height = '0;
      clear_segment();
      for (int i = 0; i < OBJECT_SLOTS; i++) begin
        tbl_version[i] = '0;
        tbl_width[i] = '0;
        tbl_height[i] = '0;
        tbl_filled[i] = '0;
        tbl_remaining[i] = '0;
        tbl_open[i] = 1'b0;
      end
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAX_WIDTH) lim_width = cfg_data_i;
        else lim_height = cfg_data_i;
      end
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result transfer", $realtime);
          fail_count++;
        end else begin
          w = expected_results.pop_front();
          if (res.result_kind !== w.kind)
            report_mismatch("kind", 32'(res.result_kind), 32'(w.kind));
          if (res.obj_id !== w.obj_id)
            report_mismatch("obj_id", 32'(res.obj_id), 32'(w.obj_id));
          if (res.buffer_offset !== w.buffer_offset)
            report_mismatch("buffer_offset", 32'(res.buffer_offset), 32'(w.buffer_offset));
          if (res.payload !== w.payload)
            report_mismatch("payload", 32'(res.payload), 32'(w.payload));
          if (res.status !== w.status)
            report_mismatch("status", 32'(res.status), 32'(w.status));
          if (res.object_width !== w.object_width)
            report_mismatch("object_width", 32'(res.object_width), 32'(w.object_width));
          if (res.object_height !== w.object_height)
            report_mismatch("object_height", 32'(res.object_height), 32'(w.object_height));
          if (res.data_length !== w.data_length)
            report_mismatch("data_length", 32'(res.data_length), 32'(w.data_length));
        end
      end
      if (seg.valid && seg.ready) predict_byte(seg.seg_byte, seg.seg_last);
    end
  end

endmodule

// ===== dv/subtitle_object_fragment_reassembler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_object_fragment_reassembler_unit_tb
// Drives object definition segments, well formed and broken, into the
// reassembler with random gaps and stalls; a checker grades every result.
// ----------------------------------------------------------------------------
module subtitle_object_fragment_reassembler_unit_tb;
  import sofr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_MAX_WIDTH;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          pending_count;
  int          bytes_sent;
  bit          hold_off_req;
  bit          holding;
  bit          done;
  int          idle_cycles;

  sofr_seg_if seg ();
  sofr_res_if res ();

  subtitle_object_fragment_reassembler_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .seg_in(seg.sink), .res_out(res.source)
  );

  sofr_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .seg(seg), .res(res), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  always #5 clk_i = ~clk_i;

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    bit hold_done;
    res.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req && !hold_done) begin
        holding = 1'b1;
        res.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        holding = 1'b0;
        hold_done = 1'b1;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        res.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
      while (!res.valid) @(posedge clk_i);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((seg.valid && seg.ready) || (res.valid && res.ready) || holding)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("subtitle_object_fragment_reassembler_unit regression: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit no_gap = 0);
    int n;
    n = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (n > 0) begin
      seg.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    seg.valid <= 1'b1;
    seg.seg_byte <= b;
    seg.seg_last <= last;
    @(posedge clk_i);
    while (!seg.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_segment(input logic [7:0] bytes[$], input bit no_gap = 0);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, no_gap);
  endtask

  // First fragment header: id, version, descriptor, length, width, height.
  function automatic void first_header(ref logic [7:0] q[$], input logic [15:0] id,
                                       input logic [7:0] ver, input logic [7:0] desc,
                                       input logic [23:0] len, input logic [15:0] w,
                                       input logic [15:0] h);
    q = {id[15:8], id[7:0], ver, desc, len[23:16], len[15:8], len[7:0],
         w[15:8], w[7:0], h[15:8], h[7:0]};
  endfunction

  // Stop offering bytes and wait until every expected result has come.
  task automatic wait_drained();
    seg.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [15:0] w, input logic [15:0] h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MAX_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random object: first fragment then continuations, with errors mixed in.
  task automatic random_object();
    logic [7:0]  q[$];
    logic [15:0] id;
    logic [7:0]  ver;
    logic [23:0] len;
    int          body, frags, k, r;
    id = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(64, 65535)) :
                                        16'($urandom_range(0, 63));
    ver = 8'($urandom);
    body = $urandom_range(0, 12);
    len = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 3)) : 24'(body + 4);
    frags = $urandom_range(1, 3);
    r = $urandom_range(0, 19);
    first_header(q, id, ver, (frags == 1) ? 8'hc0 : 8'h80, len,
                 (r == 0) ? 16'h0 : 16'($urandom_range(1, 700)),
                 (r == 1) ? 16'h0 : 16'($urandom_range(1, 700)));
    if (r == 2) q[3] = q[3] | 8'h01;
    k = $urandom_range(0, body);
    if (frags == 1) k = body + $urandom_range(0, 1);
    repeat (k) q.push_back(8'($urandom));
    if (r == 3) q = q[0:$urandom_range(0, 9)];
    send_segment(q);
    for (int f = 1; f < frags; f++) begin
      q = {id[15:8], id[7:0], ($urandom_range(0, 7) == 0) ? ver + 8'd1 : ver,
           (f == frags - 1) ? 8'h40 : 8'h00};
      repeat ($urandom_range(0, 7)) q.push_back(8'($urandom));
      send_segment(q);
    end
  endtask

  initial begin
    logic [7:0] q[$];
    seg.valid = 1'b0;
    seg.seg_byte = '0;
    seg.seg_last = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with limits disabled.
    first_header(q, 16'd0, 8'd1, 8'hc0, 24'd6, 16'hffff, 16'hffff);
    q.push_back(8'h00); q.push_back(8'hff); q.push_back(8'haa);
    send_segment(q);
    send_segment('{8'h00});
    send_segment('{8'h00, 8'h05});
    send_segment('{8'h00, 8'h05, 8'h00, 8'h3f});
    send_segment('{8'h00, 8'h05, 8'h00, 8'h00});
    send_segment('{8'hff, 8'hff, 8'h00, 8'h80});
    first_header(q, 16'd3, 8'd2, 8'h80, 24'd3, 16'd1, 16'd1);
    send_segment(q);
    first_header(q, 16'd3, 8'd2, 8'h80, 24'd6, 16'd0, 16'd1);
    send_segment(q);
    first_header(q, 16'd3, 8'd2, 8'h80, 24'd6, 16'd4, 16'd4);
    q.push_back(8'h11);
    send_segment(q);
    send_segment('{8'h00, 8'h03, 8'h07, 8'h00, 8'h22});
    send_segment('{8'h00, 8'h03, 8'h02, 8'h40, 8'h33, 8'h44});
    first_header(q, 16'd63, 8'hff, 8'h80, 24'hffffff, 16'd2, 16'd2);
    q = q[0:7];
    send_segment(q);
    first_header(q, 16'd70, 8'd0, 8'h80, 24'd8, 16'd2, 16'd2);
    send_segment(q);
    wait_drained();

    // Limits set: exceed and fit.
    write_limits(16'd720, 16'd576);
    first_header(q, 16'd5, 8'd0, 8'hc0, 24'd5, 16'd721, 16'd10);
    send_segment(q);
    first_header(q, 16'd5, 8'd0, 8'hc0, 24'd5, 16'd720, 16'd576);
    q.push_back(8'h5a); q.push_back(8'h5b);
    send_segment(q);

    // Back-pressure: long receiver hold-off while the sender keeps going.
    hold_off_req = 1'b1;
    first_header(q, 16'd9, 8'd0, 8'h80, 24'd40, 16'd8, 16'd8);
    repeat (20) q.push_back(8'($urandom));
    send_segment(q, 1);
    wait_drained();

    // Random part under several limit settings, extremes included.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_limits(16'hffff, 16'hffff);
        1: write_limits(16'd1, 16'd1);
        2: write_limits(16'd0, 16'd300);
        default: write_limits(16'($urandom_range(200, 700)), 16'($urandom_range(200, 700)));
      endcase
      while (bytes_sent < 470 * (p + 1)) begin
        if ($urandom_range(0, 9) == 0) begin
          q.delete();
          repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
          send_segment(q);
        end else random_object();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("subtitle_object_fragment_reassembler_unit regression: pass");
    else
      $display("subtitle_object_fragment_reassembler_unit regression: fail");
    $finish;
  end

endmodule
